// ===== rtl/fmks_pkg.sv =====
package fmks_pkg;

  localparam int MAX_KEYS    = 8;
  localparam int MAX_PERIODS = 4;

  localparam int KEY_W   = 3;
  localparam int WORD_W  = 5;
  localparam int ADDR_W  = KEY_W + WORD_W;
  localparam int MEM_D   = 256;
  localparam int DATA_W  = 64;
  localparam int DIV_W   = 32;
  localparam int PER_W   = 3;
  localparam int CNT_W   = 4;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] STAT_WRITTEN = 2'd0;
  localparam logic [1:0] STAT_MATCH   = 2'd1;
  localparam logic [1:0] STAT_NONE    = 2'd2;

  localparam logic [1:0] KIND_VIDEO = 2'd0;
  localparam logic [1:0] KIND_AUDIO = 2'd1;

  localparam logic [WORD_W-1:0] W_MASK    = 5'd0;
  localparam logic [WORD_W-1:0] W_BR_MIN  = 5'd1;
  localparam logic [WORD_W-1:0] W_BR_MAX  = 5'd2;
  localparam logic [WORD_W-1:0] W_PX_MIN  = 5'd3;
  localparam logic [WORD_W-1:0] W_PX_MAX  = 5'd4;
  localparam logic [WORD_W-1:0] W_FPS_MIN = 5'd5;
  localparam logic [WORD_W-1:0] W_FPS_MAX = 5'd6;
  localparam logic [WORD_W-1:0] W_CH_MIN  = 5'd7;
  localparam logic [WORD_W-1:0] W_CH_MAX  = 5'd8;
  localparam logic [WORD_W-1:0] W_PCOUNT  = 5'd9;

  // one stage of the restoring divider chain
  typedef struct packed {
    logic             vld;
    logic [DIV_W-1:0] rem;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
    logic [DIV_W-1:0] quo;
  } div_t;

endpackage

// ===== rtl/fmks_ram.sv =====
module fmks_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/fmks_div_cell.sv =====
module fmks_div_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  fmks_pkg::div_t d,
  output fmks_pkg::div_t q_r
);

  logic [fmks_pkg::DIV_W:0]   trial;
  logic [fmks_pkg::DIV_W:0]   diff;
  logic                       ge;
  fmks_pkg::div_t             q_nxt;

  always_comb begin
    trial = {d.rem, d.num[fmks_pkg::DIV_W-1]};
    diff  = trial - {1'b0, d.den};
    ge    = (trial >= {1'b0, d.den});
    q_nxt     = d;
    q_nxt.rem = ge ? diff[fmks_pkg::DIV_W-1:0] : trial[fmks_pkg::DIV_W-1:0];
    q_nxt.num = {d.num[fmks_pkg::DIV_W-2:0], 1'b0};
    q_nxt.quo = {d.quo[fmks_pkg::DIV_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end else begin
      q_r <= q_nxt;
    end
  end

endmodule

// ===== rtl/first_match_key_rule_selector_unit.sv =====
// Rule selector: a write request (tuser 0) stores one 64-bit word of the 256-word rule memory
// at entry*32+word and returns status 0 through S_FIN and the output register. A query request
// (tuser 1) first runs time_scale/frame_duration through a row of 32 divider cells, then walks
// entries 0..min(key_count,8)-1 reading one rule word at a time (S_RD, then S_EV) from the single
// read port of the rule memory; an entry reads at most 10+3*periods rule words. One request is
// worked on at a time; a finished result waits in the output register while the next request
// is taken. Entries must be written before use.
module first_match_key_rule_selector_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // op
  input  logic         in_tuser,
  // word_addr, word_data, media_kind, track_bitrate, frame_width, frame_height,
  // time_scale, frame_duration, audio_channels, clip_number, clip_start_ms, zero pad
  input  logic [303:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status
  output logic [1:0]   out_tuser,
  // key_number, zero pad
  output logic [7:0]   out_tdata,
  input  logic         cfg_wr_en,
  input  logic [3:0]   cfg_wr_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_EV   = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic [fmks_pkg::CNT_W-1:0] key_count_r;
  logic [fmks_pkg::CNT_W-1:0] limit;

  logic [1:0]  kind_r, kind_nxt;
  logic [31:0] br_r, br_nxt;
  logic [31:0] pix_r, pix_nxt;
  logic [31:0] fps_r, fps_nxt;
  logic        dnz_r, dnz_nxt;
  logic [15:0] ch_r, ch_nxt;
  logic [31:0] clip_r, clip_nxt;
  logic [47:0] tms_r, tms_nxt;

  logic [fmks_pkg::KEY_W-1:0]  k_r, k_nxt;
  logic [fmks_pkg::WORD_W-1:0] w_r, w_nxt;
  logic [fmks_pkg::PER_W-1:0]  p_r, p_nxt;
  logic [fmks_pkg::PER_W-1:0]  n_r, n_nxt;
  logic [1:0]  j_r, j_nxt;
  logic        hit_r, hit_nxt;
  logic [1:0]  stat_r, stat_nxt;
  logic [fmks_pkg::KEY_W-1:0]  res_key_r, res_key_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_stat_r, out_stat_nxt;
  logic [fmks_pkg::KEY_W-1:0] out_key_r, out_key_nxt;

  logic        in_acc;
  logic        wr_en;
  logic [fmks_pkg::DATA_W-1:0] rd;
  logic [31:0] lo;
  logic        step_ok, match, next_key;

  fmks_pkg::div_t stage [0:fmks_pkg::DIV_W];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign wr_en     = in_acc && (in_tuser == fmks_pkg::OP_WRITE);
  assign limit     = (key_count_r > fmks_pkg::CNT_W'(fmks_pkg::MAX_KEYS))
                     ? fmks_pkg::CNT_W'(fmks_pkg::MAX_KEYS) : key_count_r;

  fmks_ram #(.WIDTH(fmks_pkg::DATA_W), .DEPTH(fmks_pkg::MEM_D)) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (in_tdata[7:0]),
    .wdata (in_tdata[71:8]),
    .raddr ({k_r, w_r}),
    .rdata (rd)
  );

  assign lo = rd[31:0];

  always_comb begin
    stage[0].vld = in_acc && (in_tuser == fmks_pkg::OP_QUERY);
    stage[0].rem = '0;
    stage[0].num = in_tdata[169:138];
    stage[0].den = in_tdata[201:170];
    stage[0].quo = '0;
  end

  for (genvar i = 0; i < fmks_pkg::DIV_W; i++) begin : g_div
    fmks_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .d     (stage[i]),
      .q_r   (stage[i+1])
    );
  end

  always_comb begin
    state_nxt   = state_r;
    kind_nxt    = kind_r;
    br_nxt      = br_r;
    pix_nxt     = pix_r;
    fps_nxt     = fps_r;
    dnz_nxt     = dnz_r;
    ch_nxt      = ch_r;
    clip_nxt    = clip_r;
    tms_nxt     = tms_r;
    k_nxt       = k_r;
    w_nxt       = w_r;
    p_nxt       = p_r;
    n_nxt       = n_r;
    j_nxt       = j_r;
    hit_nxt     = hit_r;
    stat_nxt    = stat_r;
    res_key_nxt = res_key_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_stat_nxt  = out_stat_r;
    out_key_nxt   = out_key_r;
    step_ok  = 1'b1;
    match    = 1'b0;
    next_key = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          kind_nxt = in_tdata[73:72];
          br_nxt   = in_tdata[105:74];
          pix_nxt  = in_tdata[121:106] * in_tdata[137:122];
          dnz_nxt  = (in_tdata[201:170] != 32'd0);
          ch_nxt   = in_tdata[217:202];
          clip_nxt = in_tdata[249:218];
          tms_nxt  = in_tdata[297:250];
          if (in_tuser == fmks_pkg::OP_WRITE) begin
            stat_nxt    = fmks_pkg::STAT_WRITTEN;
            res_key_nxt = '0;
            state_nxt   = S_FIN;
          end else begin
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (stage[fmks_pkg::DIV_W].vld) begin
          fps_nxt = stage[fmks_pkg::DIV_W].quo;
          k_nxt   = '0;
          w_nxt   = '0;
          if (limit == '0) begin
            stat_nxt    = fmks_pkg::STAT_NONE;
            res_key_nxt = '0;
            state_nxt   = S_FIN;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        state_nxt = S_EV;
      end
      S_EV: begin
        case (w_r)
          fmks_pkg::W_MASK:    step_ok = lo[kind_r];
          fmks_pkg::W_BR_MIN:  step_ok = (br_r >= lo);
          fmks_pkg::W_BR_MAX:  step_ok = (br_r <= lo);
          fmks_pkg::W_PX_MIN:  step_ok = (kind_r != fmks_pkg::KIND_VIDEO) || (pix_r >= lo);
          fmks_pkg::W_PX_MAX:  step_ok = (kind_r != fmks_pkg::KIND_VIDEO) || (pix_r <= lo);
          fmks_pkg::W_FPS_MIN: step_ok = (kind_r != fmks_pkg::KIND_VIDEO) || !dnz_r
                                         || (fps_r >= lo);
          fmks_pkg::W_FPS_MAX: step_ok = (kind_r != fmks_pkg::KIND_VIDEO) || !dnz_r
                                         || (fps_r <= lo);
          fmks_pkg::W_CH_MIN:  step_ok = (kind_r != fmks_pkg::KIND_AUDIO)
                                         || ({16'd0, ch_r} >= lo);
          fmks_pkg::W_CH_MAX:  step_ok = (kind_r != fmks_pkg::KIND_AUDIO)
                                         || ({16'd0, ch_r} <= lo);
          fmks_pkg::W_PCOUNT: begin
            if (rd > fmks_pkg::DATA_W'(fmks_pkg::MAX_PERIODS)) begin
              n_nxt = fmks_pkg::PER_W'(fmks_pkg::MAX_PERIODS);
            end else begin
              n_nxt = rd[fmks_pkg::PER_W-1:0];
            end
            match = (n_nxt == '0);
            p_nxt = '0;
            j_nxt = '0;
          end
          default: begin
            // period words: index, start, end
            case (j_r)
              2'd0: begin
                hit_nxt = rd[63] || (rd == {32'd0, clip_r});
                j_nxt   = 2'd1;
              end
              2'd1: begin
                hit_nxt = hit_r && (rd[63] || ({16'd0, tms_r} >= rd));
                j_nxt   = 2'd2;
              end
              2'd2: begin
                if (hit_r && (rd[63] || ({16'd0, tms_r} < rd))) begin
                  match = 1'b1;
                end else if ((p_r + 1'b1) == n_r) begin
                  next_key = 1'b1;
                end else begin
                  p_nxt = p_r + 1'b1;
                  j_nxt = 2'd0;
                end
              end
              default: begin
                j_nxt = 2'd0;
              end
            endcase
          end
        endcase
        if (!step_ok) begin
          next_key = 1'b1;
        end
        if (match) begin
          stat_nxt    = fmks_pkg::STAT_MATCH;
          res_key_nxt = k_r;
          state_nxt   = S_FIN;
        end else if (next_key) begin
          if (({1'b0, k_r} + 1'b1) == limit) begin
            stat_nxt    = fmks_pkg::STAT_NONE;
            res_key_nxt = '0;
            state_nxt   = S_FIN;
          end else begin
            k_nxt     = k_r + 1'b1;
            w_nxt     = '0;
            state_nxt = S_RD;
          end
        end else begin
          w_nxt     = w_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = stat_r;
          out_key_nxt   = res_key_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      key_count_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        key_count_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    br_r      <= br_nxt;
    pix_r     <= pix_nxt;
    fps_r     <= fps_nxt;
    dnz_r     <= dnz_nxt;
    ch_r      <= ch_nxt;
    clip_r    <= clip_nxt;
    tms_r     <= tms_nxt;
    k_r       <= k_nxt;
    w_r       <= w_nxt;
    p_r       <= p_nxt;
    n_r       <= n_nxt;
    j_r       <= j_nxt;
    hit_r     <= hit_nxt;
    stat_r    <= stat_nxt;
    res_key_r <= res_key_nxt;
    out_stat_r <= out_stat_nxt;
    out_key_r  <= out_key_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_stat_r;
  assign out_tdata  = {5'd0, out_key_r};

endmodule

// ===== rtl/fmks_checker.sv =====
module fmks_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [1:0] out_tuser,
  input logic [7:0] out_tdata
);

  // a held result does not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == fmks_pkg::STAT_WRITTEN || out_tuser == fmks_pkg::STAT_MATCH
                    || out_tuser == fmks_pkg::STAT_NONE))
    else $error("bad status code");

  a_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != fmks_pkg::STAT_MATCH |-> out_tdata == 8'd0)
    else $error("key number not zero without match");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

endmodule

bind first_match_key_rule_selector_unit fmks_checker u_fmks_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tuser  (out_tuser),
  .out_tdata  (out_tdata)
);
